[sv/dcv_pkg.sv]
// ----------------------------------------------------------------------------
// dcv_pkg
// shared types and constants for the datagram checksum validator
// ----------------------------------------------------------------------------
package dcv_pkg;

	// largest datagram taken in, later bytes are dropped
	localparam int unsigned MAX_DATAGRAM = 4096;
	// byte counter width, holds MAX_DATAGRAM itself
	localparam int unsigned IDX_W = $clog2(MAX_DATAGRAM + 1);
	// checksum field bytes, and smallest datagram that carries a size
	localparam int unsigned CHK_BYTES = 4;
	localparam int unsigned MIN_LEN = 8;
	localparam logic [31:0] KEY_RESET = 32'h1234_FEDC;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_SIZE     = 2'd2,
		ST_CHECKSUM = 2'd3
	} status_t;

	// role of one byte, decided in the front part
	typedef enum logic [1:0] {
		K_SKIP    = 2'd0,
		K_CHECK   = 2'd1,
		K_SIZE    = 2'd2,
		K_PAYLOAD = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [12:0] payload_length;
		logic [31:0] computed_checksum;
	} out_item_t;

	// one classified byte in the queue
	typedef struct packed {
		kind_t            kind;
		logic [1:0]       pos;
		logic [7:0]       raw;
		logic [7:0]       mixed;
		logic             last;
		logic [IDX_W-1:0] count;
	} q_entry_t;

endpackage

[sv/datagram_checksum_validator.sv]
// ----------------------------------------------------------------------------
// datagram_checksum_validator
// checks a received datagram given one byte per transfer and reports status
// result: the last byte goes through the queue, then the back loads the result register
// throughput: one byte per cycle, sustained while the result side keeps up
// rate set by the byte counter in the front and the 32-bit add in the back
// reset: async, clears counters, sums and queue, key back to 0x1234FEDC
// ----------------------------------------------------------------------------
module datagram_checksum_validator #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	// byte channel
	input  logic               in_valid,
	output logic               in_stall,
	input  dcv_pkg::in_item_t  in_data,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output dcv_pkg::out_item_t out_data,
	// key register write
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata
);

	// classified byte path from front to queue
	logic              push;
	dcv_pkg::q_entry_t push_data;
	logic              full;

	// queue to back
	logic              pop;
	dcv_pkg::q_entry_t pop_data;
	logic              empty;

	// front: counts bytes, tags checksum, size, payload and dropped bytes,
	// pre-mixes each payload byte with its index so the back only adds
	dcv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// queue: lets the front keep taking bytes while a result waits
	dcv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back: assembles checksum and size fields, sums payload, and on the
	// last byte loads the result register; holds the last byte in the
	// queue only when an earlier result is still stalled
	dcv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.empty     (empty),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[sv/dcv_front.sv]
// ----------------------------------------------------------------------------
// dcv_front
// counts bytes of a datagram and tags each one with its role
// ----------------------------------------------------------------------------
module dcv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dcv_pkg::in_item_t in_data,
	input  logic              full,
	output logic              push,
	output dcv_pkg::q_entry_t push_data
);

	logic [dcv_pkg::IDX_W-1:0] index_q;
	logic [dcv_pkg::IDX_W-1:0] count_next;
	logic                      in_range;
	logic [7:0]                pay_idx;

	assign in_stall = full;
	assign push     = in_valid && !full;

	always_comb begin
		in_range   = index_q < dcv_pkg::IDX_W'(dcv_pkg::MAX_DATAGRAM);
		count_next = in_range ? index_q + dcv_pkg::IDX_W'(1) : index_q;
		pay_idx    = index_q[7:0] - 8'(dcv_pkg::CHK_BYTES);

		push_data.raw   = in_data.data_byte;
		push_data.mixed = in_data.data_byte ^ pay_idx;
		push_data.pos   = index_q[1:0];
		push_data.last  = in_data.last_byte;
		push_data.count = count_next;
		if (!in_range) begin
			push_data.kind = dcv_pkg::K_SKIP;
		end else if (index_q < dcv_pkg::IDX_W'(dcv_pkg::CHK_BYTES)) begin
			push_data.kind = dcv_pkg::K_CHECK;
		end else if (index_q < dcv_pkg::IDX_W'(dcv_pkg::MIN_LEN)) begin
			push_data.kind = dcv_pkg::K_SIZE;
		end else begin
			push_data.kind = dcv_pkg::K_PAYLOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (push) begin
			index_q <= in_data.last_byte ? '0 : count_next;
		end
	end

	// counter saturates at the datagram limit
	a_index_limit: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= dcv_pkg::IDX_W'(dcv_pkg::MAX_DATAGRAM))
		else $error("byte counter past datagram limit");

endmodule

[sv/dcv_queue.sv]
// ----------------------------------------------------------------------------
// dcv_queue
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module dcv_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dcv_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output dcv_pkg::q_entry_t pop_data,
	output logic              empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dcv_pkg::q_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue write while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

[sv/dcv_back.sv]
// ----------------------------------------------------------------------------
// dcv_back
// accumulates checksum, size and byte sum, and forms the status
// ----------------------------------------------------------------------------
module dcv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dcv_pkg::q_entry_t  pop_data,
	input  logic               empty,
	output logic               pop,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output logic               out_valid,
	input  logic               out_stall,
	output dcv_pkg::out_item_t out_data
);

	logic [31:0]        key_q;
	logic [31:0]        sum_q;
	logic [31:0]        rchk_q;
	logic [31:0]        dsize_q;
	logic               out_valid_q;
	dcv_pkg::out_item_t out_q;

	logic               slot_free;
	logic               finish;
	logic [7:0]         add_val;
	logic [31:0]        sum_next;
	logic [31:0]        dsize_next;
	logic [31:0]        chk_val;
	logic [12:0]        plen;
	dcv_pkg::out_item_t res;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = !empty && (!pop_data.last || slot_free);
	assign finish    = pop && pop_data.last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		add_val  = (pop_data.kind == dcv_pkg::K_PAYLOAD || pop_data.kind == dcv_pkg::K_SIZE)
			? pop_data.mixed : 8'd0;
		sum_next = sum_q + {24'd0, add_val};
		chk_val  = sum_next ^ key_q;
		plen     = 13'(pop_data.count) - 13'(dcv_pkg::CHK_BYTES);

		// a last byte may itself close the size field
		dsize_next = dsize_q;
		if (pop_data.kind == dcv_pkg::K_SIZE) begin
			dsize_next[{pop_data.pos, 3'b000} +: 8] = pop_data.raw;
		end

		// checksum and size bytes are complete once eight bytes are in
		if (pop_data.count < dcv_pkg::IDX_W'(dcv_pkg::MIN_LEN)) begin
			res.status            = dcv_pkg::ST_SHORT;
			res.payload_length    = '0;
			res.computed_checksum = '0;
		end else begin
			res.payload_length    = plen;
			res.computed_checksum = chk_val;
			if (dsize_next != {19'd0, plen}) begin
				res.status = dcv_pkg::ST_SIZE;
			end else if (rchk_q != chk_val) begin
				res.status = dcv_pkg::ST_CHECKSUM;
			end else begin
				res.status = dcv_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= dcv_pkg::KEY_RESET;
			sum_q       <= '0;
			rchk_q      <= '0;
			dsize_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_q <= cfg_wdata;
			end
			if (finish) begin
				sum_q   <= '0;
				rchk_q  <= '0;
				dsize_q <= '0;
			end else if (pop) begin
				sum_q <= sum_next;
				case (pop_data.kind)
					dcv_pkg::K_CHECK: rchk_q[{pop_data.pos, 3'b000} +: 8] <= pop_data.raw;
					dcv_pkg::K_SIZE:  dsize_q[{pop_data.pos, 3'b000} +: 8] <= pop_data.raw;
					default:          ;
				endcase
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= res;
		end
	end

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == dcv_pkg::ST_SHORT
		|-> out_q.payload_length == '0 && out_q.computed_checksum == '0)
		else $error("short datagram with nonzero length or checksum");

endmodule

[dv/datagram_checksum_validator_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datagram_checksum_validator_chk
// watches the byte and result channels, predicts each datagram verdict and
// compares every result transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module datagram_checksum_validator_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  dcv_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  dcv_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output int unsigned        fail_count,
	output int unsigned        pending
);

	// shadow of the block's datagram state and key
	logic [31:0]               key_r;
	logic [dcv_pkg::IDX_W-1:0] byte_cnt;
	logic [31:0]               byte_sum;
	logic [31:0]               rx_checksum;
	logic [31:0]               size_field;

	// predicted verdicts, oldest first
	dcv_pkg::out_item_t verdict_q[$];

	task automatic note_failure(input string what, input dcv_pkg::out_item_t want,
		input dcv_pkg::out_item_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected status %0d length %0d checksum %08h",
				want.status, want.payload_length, want.computed_checksum);
			$display("  actual   status %0d length %0d checksum %08h",
				got.status, got.payload_length, got.computed_checksum);
		end
	endtask

	task automatic absorb_byte(input dcv_pkg::in_item_t item);
		dcv_pkg::out_item_t verdict;
		logic [12:0]        pidx;
		logic [31:0]        plen;
		verdict = '0;
		if (byte_cnt < dcv_pkg::MAX_DATAGRAM) begin
			if (byte_cnt < dcv_pkg::CHK_BYTES) begin
				rx_checksum[8*byte_cnt[1:0] +: 8] = item.data_byte;
			end else begin
				pidx = byte_cnt - dcv_pkg::IDX_W'(dcv_pkg::CHK_BYTES);
				byte_sum = byte_sum + (item.data_byte ^ pidx[7:0]);
				if (pidx < 4)
					size_field[8*pidx[1:0] +: 8] = item.data_byte;
			end
			byte_cnt++;
		end
		if (item.last_byte) begin
			if (byte_cnt < dcv_pkg::MIN_LEN) begin
				verdict.status = dcv_pkg::ST_SHORT;
			end else begin
				plen = byte_cnt - dcv_pkg::CHK_BYTES;
				verdict.payload_length = plen[12:0];
				verdict.computed_checksum = byte_sum ^ key_r;
				// size check wins over checksum check
				if (size_field != plen)
					verdict.status = dcv_pkg::ST_SIZE;
				else if (rx_checksum != verdict.computed_checksum)
					verdict.status = dcv_pkg::ST_CHECKSUM;
				else
					verdict.status = dcv_pkg::ST_OK;
			end
			verdict_q = {verdict_q, verdict};
			byte_cnt = '0;
			byte_sum = '0;
			rx_checksum = '0;
			size_field = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dcv_pkg::out_item_t want;
		if (!arst_n) begin
			key_r = dcv_pkg::KEY_RESET;
			byte_cnt = '0;
			byte_sum = '0;
			rx_checksum = '0;
			size_field = '0;
			verdict_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				key_r = cfg_wdata;
			if (in_valid && !in_stall)
				absorb_byte(in_data);
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					note_failure("result transfer with no verdict pending", '0, out_data);
				end else begin
					want = verdict_q.pop_front();
					if (out_data.status != want.status ||
					    out_data.payload_length != want.payload_length ||
					    out_data.computed_checksum != want.computed_checksum)
						note_failure("result mismatch", want, out_data);
				end
			end
			pending <= verdict_q.size();
		end
	end

endmodule

[dv/datagram_checksum_validator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datagram_checksum_validator_tb
// drives whole datagrams into the validator under several checksum keys:
// directed corner datagrams first (single byte, too short, size and checksum
// faults, payload index wrap), then random traffic with bursty byte
// transfers and a patterned result stall
// ----------------------------------------------------------------------------
module datagram_checksum_validator_tb;

	// how a generated datagram is filled
	typedef enum int {
		DG_GOOD,
		DG_BAD_SIZE,
		DG_BAD_SUM,
		DG_NOISE,
		DG_ZEROS,
		DG_ONES
	} dgram_kind_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	dcv_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	dcv_pkg::out_item_t out_data;
	logic               cfg_we = 1'b0;
	logic [31:0]        cfg_wdata = '0;

	int unsigned fail_count;
	int unsigned pending;

	// key the generator uses to build matching checksums
	logic [31:0] cur_key = dcv_pkg::KEY_RESET;

	// sender burst bookkeeping and traffic counters
	int          burst_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned dgrams_sent = 0;
	logic [7:0]  dg_bytes[$];

	// receiver stall pattern: a duty window repeating inside a random period
	int stall_left = 0;
	int stall_period = 4;
	int stall_duty = 0;
	int stall_phase = 0;

	always #5 clk = ~clk;

	datagram_checksum_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	datagram_checksum_validator_chk result_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// pick a new period and duty every so often, duty 0 gives stall-free stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(16, 128);
			stall_period = $urandom_range(2, 9);
			stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period);
		end
		stall_left--;
		stall_phase = (stall_phase + 1) % stall_period;
		out_stall <= arst_n && (stall_phase < stall_duty);
	end

	// one byte transfer, entered and left at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		// between bursts the sender usually pauses, sometimes chains straight on
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last_byte: last};
		// stall is settled by the falling edge, so decide there and accept at the next rise
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		bytes_sent++;
	endtask

	// build one datagram of len bytes and send it, last mark on its final byte
	task automatic send_datagram(input int len, input dgram_kind_t kind);
		int          kept;
		logic [31:0] field;
		logic [31:0] psum;
		dg_bytes.delete();
		for (int i = 0; i < len; i++) begin
			if (kind == DG_ZEROS)
				dg_bytes = {dg_bytes, 8'h00};
			else if (kind == DG_ONES)
				dg_bytes = {dg_bytes, 8'hFF};
			else
				dg_bytes = {dg_bytes, 8'($urandom)};
		end
		if (len >= dcv_pkg::MIN_LEN &&
		    (kind == DG_GOOD || kind == DG_BAD_SIZE || kind == DG_BAD_SUM)) begin
			// only the first MAX_DATAGRAM bytes count, the rest is truncated away
			kept = (len > dcv_pkg::MAX_DATAGRAM) ? dcv_pkg::MAX_DATAGRAM : len;
			field = kept - dcv_pkg::CHK_BYTES;
			if (kind == DG_BAD_SIZE)
				field ^= 32'(1) << $urandom_range(0, 31);
			for (int i = 0; i < 4; i++)
				dg_bytes[dcv_pkg::CHK_BYTES + i] = field[8*i +: 8];
			// size bytes are part of the payload, so sum after placing them
			psum = '0;
			for (int i = dcv_pkg::CHK_BYTES; i < kept; i++)
				psum += dg_bytes[i] ^ 8'(i - dcv_pkg::CHK_BYTES);
			field = psum ^ cur_key;
			if (kind == DG_BAD_SUM)
				field ^= 32'(1) << $urandom_range(0, 31);
			for (int i = 0; i < 4; i++)
				dg_bytes[i] = field[8*i +: 8];
		end
		for (int i = 0; i < len; i++)
			send_byte(dg_bytes[i], i == len - 1);
		dgrams_sent++;
	endtask

	// stop sending and let every pending verdict come out, then settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_key(input logic [31:0] k);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_key = k;
	endtask

	// random datagrams until enough bytes and verdicts for this key
	task automatic random_phase();
		int unsigned bytes_start;
		int unsigned dgrams_start;
		int          len;
		int          pick;
		dgram_kind_t kind;
		bytes_start = bytes_sent;
		dgrams_start = dgrams_sent;
		while (bytes_sent - bytes_start < 60 || dgrams_sent - dgrams_start < 3) begin
			// mostly short datagrams, a few long enough to wrap the payload index
			pick = $urandom_range(0, 99);
			if (pick < 85)
				len = $urandom_range(1, 20);
			else if (pick < 98)
				len = $urandom_range(21, 80);
			else
				len = $urandom_range(81, 300);
			// well-formed most often, then checksum and size faults, then raw noise
			pick = $urandom_range(0, 99);
			if (pick < 45)
				kind = DG_GOOD;
			else if (pick < 65)
				kind = DG_BAD_SUM;
			else if (pick < 80)
				kind = DG_BAD_SIZE;
			else
				kind = DG_NOISE;
			send_datagram(len, kind);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed datagrams under the reset key
		send_datagram(1, DG_NOISE);       // single byte
		send_datagram(7, DG_ONES);        // one short of a size field
		send_datagram(4, DG_ZEROS);       // checksum bytes only
		send_datagram(8, DG_GOOD);        // smallest valid datagram
		send_datagram(8, DG_BAD_SIZE);
		send_datagram(8, DG_BAD_SUM);
		send_datagram(8, DG_ZEROS);       // declared size zero
		send_datagram(12, DG_ONES);
		send_datagram(9, DG_GOOD);
		send_datagram(270, DG_GOOD);      // payload index wraps past 255
		drain();

		// random traffic under key extremes and random keys
		write_key(32'h0000_0000);
		random_phase();
		drain();
		write_key(32'hFFFF_FFFF);
		random_phase();
		drain();
		write_key($urandom);
		random_phase();
		drain();
		write_key($urandom);
		random_phase();
		drain();

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
